// File: hw/rtl/assert_macros.svh
// Assertion macros used by first_fit_segment_allocator.sv.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// File: hw/rtl/ffsa_pkg.sv
// Package for the first-fit segment allocator: types, codes and defaults.
// Depends on nothing.
`default_nettype none
package ffsa_pkg;
	localparam int unsigned ArenaBytesDef = 65536;
	localparam int unsigned HeaderBytesDef = 16;
	localparam int unsigned MaxSegmentsDef = 64;
	localparam int unsigned AddrW = 16;
	localparam int unsigned SizeW = 17;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_SPLIT_FIN,
		S_FREE_NX_RD,
		S_FREE_NX_CHK,
		S_FREE_PV_RD,
		S_FREE_PV_CHK,
		S_DROP_RD,
		S_DROP_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [AddrW-1:0] payload_address;
		logic [1:0] status;
	} result_t;
endpackage
`default_nettype wire

// File: hw/rtl/ffsa_stream_if.sv
// Valid/ready channel interface carrying one word per handshake.
// Depends on nothing.
`default_nettype none
interface ffsa_stream_if #(parameter int unsigned W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ffsa_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ffsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// File: hw/rtl/first_fit_segment_allocator.sv
// First-fit segment allocator top level: sequencer over one segment table RAM.
// Each request scans the entries in order; a split or a merge then shifts the entries
// behind it, one at a time (a free may merge twice).
// Takes one request at a time; not ready again until the result word is taken.
// After reset a clearing pass first writes every entry of the table.
// Depends on ffsa_pkg, ffsa_stream_if, ffsa_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module first_fit_segment_allocator #(
	parameter int unsigned ARENA_BYTES = ffsa_pkg::ArenaBytesDef,
	parameter int unsigned HEADER_BYTES = ffsa_pkg::HeaderBytesDef,
	parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDef
) (
	input wire logic clk,
	input wire logic arst_n,
	ffsa_stream_if.sink req,
	ffsa_stream_if.source rsp
);
	import ffsa_pkg::*;
	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned EW = AddrW + AddrW + 1;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);
	localparam logic [SizeW-1:0] Hdr = SizeW'(HEADER_BYTES);
	localparam logic [AddrW-1:0] Hdr16 = AddrW'(HEADER_BYTES);
	localparam logic [SizeW-1:0] Size0 = SizeW'(ARENA_BYTES - HEADER_BYTES);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, idx_q, ptr_q;
	logic [IW-1:0] addr;
	logic we;
	logic [EW-1:0] wdata, rdata;
	logic typ_q;
	logic [AddrW-1:0] key_q, cur_off_q, cur_size_q, res_addr_q;
	logic [1:0] res_st_q;
	logic out_v_q;
	logic [AddrW-1:0] r_off, r_size;
	logic r_free;
	logic [SizeW-1:0] sum_a, sum_b, sum;
	logic [SizeW:0] diff;

	assign r_off = rdata[EW-1 -: AddrW];
	assign r_size = rdata[AddrW:1];
	assign r_free = rdata[0];

	ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_tab (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	// Shared adder and subtractor.
	always_comb begin
		sum_a = SizeW'(cur_size_q);
		sum_b = SizeW'(r_size);
		case (state_q)
			S_SCAN_CHK: begin
				sum_a = SizeW'(key_q);
				sum_b = Hdr;
			end
			S_SPLIT_FIN: begin
				sum_a = SizeW'(cur_off_q);
				sum_b = SizeW'(key_q);
			end
			default: ;
		endcase
		sum = sum_a + sum_b + Hdr;
		if (state_q == S_SCAN_CHK) sum = sum_a + sum_b;
		diff = {2'b0, r_size} - {1'b0, sum};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: if (idx_q == MaxCnt - CW'(1)) state_d = S_IDLE;
			S_IDLE: if (req.valid && !out_v_q) state_d = S_SCAN_RD;
			S_SCAN_RD: state_d = (idx_q >= cnt_q) ? S_DONE : S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (typ_q == 1'b0) begin
					if (r_free && r_size >= key_q) begin
						if (r_size == key_q) state_d = S_DONE;
						else if (diff[SizeW] == 1'b0 && diff != '0) begin
							state_d = (cnt_q >= MaxCnt) ? S_DONE : S_SPLIT_RD;
						end else state_d = S_DONE;
					end else state_d = S_SCAN_RD;
				end else begin
					if (!r_free && r_off + Hdr16 == key_q
							&& ({1'b0, r_off} + Hdr) <= SizeW'(16'hFFFF)) begin
						state_d = S_FREE_NX_RD;
					end else state_d = S_SCAN_RD;
				end
			end
			S_SPLIT_RD: state_d = (ptr_q > idx_q + CW'(1)) ? S_SPLIT_WR : S_SPLIT_FIN;
			S_SPLIT_WR: state_d = S_SPLIT_RD;
			S_SPLIT_FIN: state_d = S_DONE;
			S_FREE_NX_RD: state_d = (idx_q + CW'(1) < cnt_q) ? S_FREE_NX_CHK : S_FREE_PV_RD;
			S_FREE_NX_CHK: state_d = r_free ? S_DROP_RD : S_FREE_PV_RD;
			S_FREE_PV_RD: state_d = (idx_q != '0) ? S_FREE_PV_CHK : S_DONE;
			S_FREE_PV_CHK: state_d = r_free ? S_DROP_RD : S_DONE;
			S_DROP_RD: state_d = (ptr_q + CW'(1) < cnt_q) ? S_DROP_WR : S_FREE_PV_RD;
			S_DROP_WR: state_d = S_DROP_RD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		addr = idx_q[IW-1:0];
		wdata = {cur_off_q, cur_size_q, 1'b1};
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				wdata = (idx_q == '0) ? {AddrW'(0), Size0[AddrW-1:0], 1'b1} : '0;
			end
			S_SCAN_CHK: begin
				if (typ_q == 1'b0 && state_d == S_DONE && r_free && r_size == key_q) begin
					we = 1'b1;
					wdata = {r_off, r_size, 1'b0};
				end
				if (typ_q == 1'b0 && state_d == S_SPLIT_RD) begin
					we = 1'b1;
					wdata = {r_off, key_q, 1'b0};
				end
				if (typ_q == 1'b1 && state_d == S_FREE_NX_RD) begin
					we = 1'b1;
					wdata = {r_off, r_size, 1'b1};
				end
			end
			S_SPLIT_RD: addr = IW'(ptr_q - CW'(1));
			S_SPLIT_WR: begin
				we = 1'b1;
				addr = ptr_q[IW-1:0];
				wdata = rdata;
			end
			S_SPLIT_FIN: begin
				we = 1'b1;
				addr = IW'(idx_q + CW'(1));
				wdata = {sum[AddrW-1:0], cur_size_q - key_q - Hdr16, 1'b1};
			end
			S_FREE_NX_RD: addr = IW'(idx_q + CW'(1));
			S_FREE_NX_CHK: begin
				if (r_free) begin
					we = 1'b1;
					wdata = {cur_off_q, sum[AddrW-1:0], 1'b1};
				end
			end
			S_FREE_PV_RD: addr = IW'(idx_q - CW'(1));
			S_FREE_PV_CHK: begin
				addr = IW'(idx_q - CW'(1));
				if (r_free) begin
					we = 1'b1;
					wdata = {r_off, sum[AddrW-1:0], 1'b1};
				end
			end
			S_DROP_RD: addr = IW'(ptr_q + CW'(1));
			S_DROP_WR: begin
				we = 1'b1;
				addr = ptr_q[IW-1:0];
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				typ_q <= req.data[0];
				key_q <= req.data[0] ? req.data[2*AddrW:AddrW+1] : req.data[AddrW:1];
			end
			S_SCAN_CHK: begin
				cur_off_q <= r_off;
				cur_size_q <= r_size;
			end
			S_FREE_NX_CHK, S_FREE_PV_CHK: begin
				if (r_free) begin
					cur_size_q <= AddrW'(sum);
					if (state_q == S_FREE_PV_CHK) cur_off_q <= r_off;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= CW'(1);
			idx_q <= '0;
			ptr_q <= '0;
			out_v_q <= 1'b0;
			res_st_q <= ST_OK;
			res_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_INIT: idx_q <= idx_q + CW'(1);
				S_IDLE: begin
					if (!out_v_q) begin
						idx_q <= '0;
						res_st_q <= req.data[0] ? ST_UNKNOWN : ST_NOFIT;
						res_addr_q <= '0;
					end
				end
				S_SCAN_CHK: begin
					if (state_d == S_SCAN_RD) idx_q <= idx_q + CW'(1);
					else if (typ_q == 1'b0) begin
						if (r_free && r_size == key_q) begin
							res_st_q <= ST_OK;
							res_addr_q <= r_off + Hdr16;
						end else if (state_d == S_SPLIT_RD) begin
							ptr_q <= cnt_q;
						end else if (cnt_q >= MaxCnt && diff[SizeW] == 1'b0 && diff != '0)
							res_st_q <= ST_FULL;
					end else begin
						res_st_q <= ST_OK;
					end
				end
				S_SPLIT_WR: ptr_q <= ptr_q - CW'(1);
				S_SPLIT_FIN: begin
					cnt_q <= cnt_q + CW'(1);
					res_st_q <= ST_OK;
					res_addr_q <= cur_off_q + Hdr16;
				end
				S_FREE_NX_CHK: if (r_free) ptr_q <= idx_q + CW'(1);
				S_FREE_PV_CHK: if (r_free) begin
					idx_q <= idx_q - CW'(1);
					ptr_q <= idx_q;
				end
				S_DROP_RD: if (state_d == S_FREE_PV_RD) cnt_q <= cnt_q - CW'(1);
				S_DROP_WR: ptr_q <= ptr_q + CW'(1);
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = {res_addr_q, res_st_q};

	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q >= CW'(1) && cnt_q <= MaxCnt)
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, req.ready, !rsp.valid)
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == S_DONE, rsp.valid)
endmodule
`default_nettype wire
